[design/olist_pkg.sv]
`default_nettype none

package olist_pkg;

   localparam int LIST_DEPTH_DEF = 16;

   localparam int KEY_W    = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND  = 2'd0,
      OP_FIND    = 2'd1,
      OP_REPLACE = 2'd2,
      OP_REMOVE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   // per-cell control for one cycle
   typedef struct packed {
      logic capture;   // latch compare result against the incoming key
      logic load;      // take the broadcast write value
      logic shift;     // take the right-hand neighbor's value
   } cell_ctl_type;

endpackage

`default_nettype wire

[design/olist_cell.sv]
`default_nettype none

module olist_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 5
) (
   input  wire logic                      clock,
   input  wire olist_pkg::cell_ctl_type   ctl,
   input  wire logic [olist_pkg::KEY_W-1:0] cmp_key,
   input  wire logic [CNT_W-1:0]          count,
   input  wire logic [olist_pkg::KEY_W-1:0] wr_data,
   input  wire logic [olist_pkg::KEY_W-1:0] next_data,
   output logic      [olist_pkg::KEY_W-1:0] data,
   output logic                           match
);
   import olist_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

   logic [KEY_W-1:0] data_ff;
   logic [KEY_W-1:0] data_in;
   logic             match_ff;
   logic             match_in;

   // only entries below the fill count take part in a search
   assign match_in = (data_ff == cmp_key) && (MY_INDEX < count);

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = wr_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctl.capture) begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

[design/olist_resolve.sv]
`default_nettype none

module olist_resolve #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  wire logic [DEPTH-1:0] match_vec,
   output logic      [DEPTH-1:0] first_hot,
   output logic      [DEPTH-1:0] shift_mask,
   output logic      [IDX_W-1:0] first_idx,
   output logic                  any_match
);
   import olist_pkg::*;

   logic [DEPTH-1:0] dec_vec;

   // m-1 clears the lowest set bit and sets all bits below it
   assign dec_vec    = match_vec - DEPTH'(1);
   assign first_hot  = match_vec & ~dec_vec;
   // cells at or above the first match close the gap on remove
   assign shift_mask = ~(match_vec ^ dec_vec) | first_hot;
   assign any_match  = |match_vec;

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hot[i]) begin
            first_idx = first_idx | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[design/ordered_value_list.sv]
// Bounded ordered list of signed 32-bit values held in a row of LIST_DEPTH
// cells. A request transaction carries an operation (append, find, replace
// first match, remove first match) and returns one response transaction with
// status, position and the entry count after the operation. On acceptance of
// a request every cell compares its entry against the key in parallel and
// latches the result; once the response register is free, the first match
// is picked out, the cells are updated (remove shifts every cell above the
// match down by one in the same update) and the response is registered.
// A new request is taken only after the previous one has been executed.
// Positions wider than 4 bits and counts wider than 5 bits are reported in
// their low bits.
`default_nettype none

module ordered_value_list #(
   parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [1:0] opcode, [33:2] key_value, [65:34] new_value, [71:66] zero
   input  wire logic [olist_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [1:0] status, [5:2] position, [10:6] entry_count, [15:11] zero
   output logic      [olist_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import olist_pkg::*;

   localparam int IDX_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int PWIDE  = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam int CWIDE  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff;
   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   new_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [KEY_W-1:0]   req_key;
   logic [KEY_W-1:0]   req_new;
   op_type             req_op;
   logic               req_fire;
   logic               exec_go;

   cell_ctl_type       cell_ctl [LIST_DEPTH];
   logic [KEY_W-1:0]   cell_data [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] match_vec;
   logic [LIST_DEPTH-1:0] first_hot;
   logic [LIST_DEPTH-1:0] shift_mask;
   logic [IDX_W-1:0]   first_idx;
   logic               any_match;
   logic [KEY_W-1:0]   wr_data;

   status_type         status_in;
   logic [CNT_W-1:0]   count_in;
   logic [PWIDE-1:0]   pos_wide;
   logic [CWIDE-1:0]   count_wide;

   assign req_op   = op_type'(req_tdata[OP_W-1:0]);
   assign req_key  = req_tdata[OP_W +: KEY_W];
   assign req_new  = req_tdata[OP_W+KEY_W +: KEY_W];

   // no transaction is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign wr_data = (op_ff == OP_APPEND) ? key_ff : new_ff;

   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         cell_ctl[i].capture = req_fire;
         cell_ctl[i].load    = 1'b0;
         cell_ctl[i].shift   = 1'b0;
         if (exec_go) begin
            case (op_ff)
               OP_APPEND: begin
                  cell_ctl[i].load = (count_ff == CNT_W'(i));
               end
               OP_REPLACE: begin
                  cell_ctl[i].load = first_hot[i];
               end
               OP_REMOVE: begin
                  cell_ctl[i].shift = any_match && shift_mask[i];
               end
               default: begin
               end
            endcase
         end
      end
   end

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0] next_w;
      if (g == LIST_DEPTH - 1) begin : g_last
         assign next_w = cell_data[g];
      end else begin : g_mid
         assign next_w = cell_data[g+1];
      end
      olist_cell #(
         .CELL_INDEX (g),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[g]),
         .cmp_key   (req_key),
         .count     (count_ff),
         .wr_data   (wr_data),
         .next_data (next_w),
         .data      (cell_data[g]),
         .match     (match_vec[g])
      );
   end

   olist_resolve #(
      .DEPTH (LIST_DEPTH),
      .IDX_W (IDX_W)
   ) u_resolve (
      .match_vec  (match_vec),
      .first_hot  (first_hot),
      .shift_mask (shift_mask),
      .first_idx  (first_idx),
      .any_match  (any_match)
   );

   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      pos_wide  = '0;
      if (op_ff == OP_APPEND) begin
         if (count_ff == FULL_COUNT) begin
            status_in = ST_FULL;
         end else begin
            pos_wide = PWIDE'(count_ff);
            count_in = count_ff + CNT_W'(1);
         end
      end else if (!any_match) begin
         status_in = ST_NOTFOUND;
      end else begin
         pos_wide = PWIDE'(first_idx);
         if (op_ff == OP_REMOVE) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      count_wide = CWIDE'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  state_ff     <= S_IDLE;
                  count_ff     <= count_in;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (req_fire) begin
         op_ff  <= req_op;
         key_ff <= req_key;
         new_ff <= req_new;
      end
      if (exec_go) begin
         rsp_status_ff <= status_in;
         rsp_pos_ff    <= pos_wide[POS_W-1:0];
         rsp_count_ff  <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_pos_ff, rsp_status_ff};

endmodule

`default_nettype wire

[tb/ordered_value_list_test.sv]
`timescale 1ns / 1ps

module ordered_value_list_test;
   import olist_pkg::*;

   localparam int DEPTH       = LIST_DEPTH_DEF;
   localparam int RAND_ITEMS  = 700;
   localparam int PHASE_LEN   = 50;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      status_type status;
      logic [POS_W-1:0] pos;
      logic [COUNT_W-1:0] cnt;
   } rsp_fields_t;

   typedef struct {
      op_type op;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] nv;
      int reps;                  // key steps by one on each repeat
      bit fixed;                 // expectation typed below, else predicted
      rsp_fields_t answer;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ordered_value_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the list
   logic [KEY_W-1:0] list_mem [DEPTH];
   int held = 0;
   int peak_held = 0;

   rsp_fields_t rsp_exp_q[$];
   int errors = 0;
   int req_accepted = 0;
   int op_cnt [4] = '{0, 0, 0, 0};
   int ok_seen = 0, miss_seen = 0, full_seen = 0;
   bit no_idle = 1'b0;
   bit hold_done = 1'b0;

   function automatic rsp_fields_t list_update(input op_type op, input logic [KEY_W-1:0] key,
                                               input logic [KEY_W-1:0] nv);
      rsp_fields_t r;
      int hit;
      int where;
      r.status = ST_OK;
      where = 0;
      hit = -1;
      if (op == OP_APPEND) begin
         if (held >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            list_mem[held] = key;
            where = held;
            held++;
         end
      end else begin
         for (int i = 0; i < held; i++)
            if (hit < 0 && list_mem[i] == key) hit = i;
         if (hit < 0) begin
            r.status = ST_NOTFOUND;
         end else begin
            where = hit;
            if (op == OP_REPLACE) begin
               list_mem[hit] = nv;
            end else if (op == OP_REMOVE) begin
               for (int j = hit; j + 1 < held; j++) list_mem[j] = list_mem[j + 1];
               held--;
            end
         end
      end
      r.pos = where[POS_W-1:0];
      r.cnt = held[COUNT_W-1:0];
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // small set of values so duplicates and hits are common
   function automatic logic [KEY_W-1:0] pool_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return 32'h0000_0002;
         6: return 32'hFFFF_FFFE;
         default: return 32'h5555_5555;
      endcase
   endfunction

   task automatic send_req(input op_type op, input logic [KEY_W-1:0] key,
                           input logic [KEY_W-1:0] nv, input bit fixed,
                           input rsp_fields_t answer);
      int gap;
      rsp_fields_t pred;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, nv, key, op};
      do @(posedge clock); while (!req_tready);
      pred = list_update(op, key, nv);
      rsp_exp_q.push_back(fixed ? answer : pred);
      req_accepted++;
      op_cnt[op]++;
      if (held > peak_held) peak_held = held;
   endtask

   dir_row_t dir_tab[] = '{
      '{OP_FIND,    32'h0000_0005, 32'h0, 1, 1, '{ST_NOTFOUND, 4'd0, 5'd0}},
      '{OP_REMOVE,  32'h0000_0005, 32'h0, 1, 1, '{ST_NOTFOUND, 4'd0, 5'd0}},
      '{OP_REPLACE, 32'h0000_0005, 32'h7, 1, 1, '{ST_NOTFOUND, 4'd0, 5'd0}},
      '{OP_APPEND,  32'h8000_0000, 32'h0, 1, 1, '{ST_OK, 4'd0, 5'd1}},
      '{OP_APPEND,  32'h7FFF_FFFF, 32'h0, 1, 1, '{ST_OK, 4'd1, 5'd2}},
      '{OP_APPEND,  32'hFFFF_FFFF, 32'h0, 1, 1, '{ST_OK, 4'd2, 5'd3}},
      '{OP_APPEND,  32'h7FFF_FFFF, 32'h0, 1, 1, '{ST_OK, 4'd3, 5'd4}},
      // duplicate: lowest index wins
      '{OP_FIND,    32'h7FFF_FFFF, 32'h0, 1, 1, '{ST_OK, 4'd1, 5'd4}},
      '{OP_REPLACE, 32'h7FFF_FFFF, 32'h0, 1, 1, '{ST_OK, 4'd1, 5'd4}},
      '{OP_FIND,    32'h7FFF_FFFF, 32'h0, 1, 1, '{ST_OK, 4'd3, 5'd4}},
      '{OP_REMOVE,  32'h8000_0000, 32'h0, 1, 1, '{ST_OK, 4'd0, 5'd3}},
      '{OP_FIND,    32'h8000_0000, 32'h0, 1, 1, '{ST_NOTFOUND, 4'd0, 5'd3}},
      // fill to the top
      '{OP_APPEND,  32'h0000_0100, 32'h0, 13, 0, '{ST_OK, 4'd0, 5'd0}},
      '{OP_APPEND,  32'h1234_5678, 32'h0, 1, 1, '{ST_FULL, 4'd0, 5'd16}},
      '{OP_FIND,    32'h0000_010C, 32'h0, 1, 0, '{ST_OK, 4'd0, 5'd0}},
      '{OP_REMOVE,  32'h0000_010C, 32'h0, 1, 0, '{ST_OK, 4'd0, 5'd0}},
      '{OP_REMOVE,  32'h0000_0000, 32'h0, 1, 0, '{ST_OK, 4'd0, 5'd0}},
      '{OP_REPLACE, 32'h0000_0105, 32'hAAAA_AAAA, 1, 0, '{ST_OK, 4'd0, 5'd0}},
      '{OP_REPLACE, 32'h5555_5555, 32'h1, 1, 1, '{ST_NOTFOUND, 4'd0, 5'd14}}
   };

   // response checker
   always @(posedge clock) begin
      rsp_fields_t got;
      rsp_fields_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.pos = rsp_tdata[5:2];
         got.cnt = rsp_tdata[10:6];
         case (got.status)
            ST_OK:       ok_seen++;
            ST_NOTFOUND: miss_seen++;
            ST_FULL:     full_seen++;
            default:     ;
         endcase
         if (rsp_exp_q.size() == 0) begin
            $display("%0t: unexpected response transaction, actual status %0d pos %0d count %0d",
                     $time, got.status, got.pos, got.cnt);
            errors++;
         end else begin
            want = rsp_exp_q.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want.status, got.status);
               errors++;
            end
            if (got.pos !== want.pos) begin
               $display("%0t: position mismatch, expected %0d actual %0d",
                        $time, want.pos, got.pos);
               errors++;
            end
            if (got.cnt !== want.cnt) begin
               $display("%0t: entry_count mismatch, expected %0d actual %0d",
                        $time, want.cnt, got.cnt);
               errors++;
            end
         end
      end
   end

   // response side: random stalls, plus one long hold while requests keep coming
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && req_accepted >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            gap = no_idle ? 0 : pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int r;
      int phase;
      op_type op;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] nv;
      for (int i = 0; i < DEPTH; i++) list_mem[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         for (int k = 0; k < dir_tab[i].reps; k++)
            send_req(dir_tab[i].op, dir_tab[i].key + k, dir_tab[i].nv, dir_tab[i].fixed,
                     dir_tab[i].answer);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         phase = n / PHASE_LEN;
         no_idle = (phase % 3 == 0) || (req_accepted >= HOLD_AT - 20 && !hold_done);
         r = $urandom_range(0, 99);
         // alternate growing and shrinking phases so full and empty both come up
         if (phase % 2 == 0)
            op = (r < 55) ? OP_APPEND : (r < 70) ? OP_FIND : (r < 85) ? OP_REPLACE : OP_REMOVE;
         else
            op = (r < 12) ? OP_APPEND : (r < 35) ? OP_FIND : (r < 55) ? OP_REPLACE : OP_REMOVE;
         r = $urandom_range(0, 99);
         if (op != OP_APPEND && held > 0 && r < 70)
            key = list_mem[$urandom_range(0, held - 1)];
         else if (r < 85)
            key = pool_value();
         else
            key = $urandom;
         nv = ($urandom_range(0, 99) < 40) ? pool_value() : 32'($urandom);
         send_req(op, key, nv, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      while (rsp_exp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests (%0d append, %0d find, %0d replace, %0d remove), peak %0d",
               req_accepted, op_cnt[OP_APPEND], op_cnt[OP_FIND], op_cnt[OP_REPLACE],
               op_cnt[OP_REMOVE], peak_held);
      $display("answers: %0d ok, %0d not found, %0d full; one %0d-cycle response hold",
               ok_seen, miss_seen, full_seen, HOLD_CYCLES);
      if (errors == 0 && rsp_exp_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
